FILE: design/socks5_handshake_parser_core_defines.svh
// Assertion macros for the module that checks its own logic.
`ifndef SOCKS5_HANDSHAKE_PARSER_CORE_DEFINES_SVH
`define SOCKS5_HANDSHAKE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define S5HP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define S5HP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/s5hp_pkg.sv
package s5hp_pkg;

  localparam logic [3:0] PH_G_VER   = 4'd0;
  localparam logic [3:0] PH_G_NMETH = 4'd1;
  localparam logic [3:0] PH_G_METH  = 4'd2;
  localparam logic [3:0] PH_G_DONE  = 4'd3;
  localparam logic [3:0] PH_R_VER   = 4'd4;
  localparam logic [3:0] PH_R_CMD   = 4'd5;
  localparam logic [3:0] PH_R_RSV   = 4'd6;
  localparam logic [3:0] PH_R_ATYP  = 4'd7;
  localparam logic [3:0] PH_R_ALEN  = 4'd8;
  localparam logic [3:0] PH_R_ADDR  = 4'd9;
  localparam logic [3:0] PH_R_PORT  = 4'd10;
  localparam logic [3:0] PH_R_DONE  = 4'd11;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_VER  = 3'd1;
  localparam logic [2:0] ST_BAD_CMD  = 3'd2;
  localparam logic [2:0] ST_BAD_ATYP = 3'd3;
  localparam logic [2:0] ST_G_JUNK   = 3'd4;
  localparam logic [2:0] ST_R_JUNK   = 3'd5;

  localparam logic [7:0] SOCKS_VERSION = 8'd5;
  localparam logic [7:0] CMD_CONNECT   = 8'd1;
  localparam logic [7:0] CMD_UDP_ASSOC = 8'd3;
  localparam logic [7:0] ATYP_IPV4     = 8'd1;
  localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
  localparam logic [7:0] ATYP_IPV6     = 8'd4;
  localparam logic [7:0] METHOD_MAX    = 8'd2;
  localparam logic [7:0] IPV4_LEN      = 8'd4;
  localparam logic [7:0] IPV6_LEN      = 8'd16;
  localparam logic [7:0] PORT_LEN      = 8'd2;

  typedef struct packed {
    logic [3:0]  phase;
    logic [7:0]  count;
    logic [7:0]  index;
    logic [2:0]  methods;
    logic [7:0]  command;
    logic [7:0]  atyp;
    logic [15:0] port;
    logic [2:0]  error;
  } s5hp_state_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        complete;
    logic [2:0]  method_mask;
    logic [7:0]  command;
    logic [7:0]  address_type;
    logic [15:0] port;
    logic        addr_valid;
    logic [7:0]  addr_index;
    logic [7:0]  addr_byte;
  } s5hp_result_t;

  localparam s5hp_state_t STATE_RESET = '{
    phase: PH_G_VER, count: 8'd0, index: 8'd0, methods: 3'd0,
    command: 8'd0, atyp: 8'd0, port: 16'd0, error: ST_OK
  };

endpackage

FILE: design/s5hp_step.sv
module s5hp_step (
  input  s5hp_pkg::s5hp_state_t  cur,
  input  logic                   op,
  input  logic [7:0]             data_byte,
  input  logic                   first,
  output s5hp_pkg::s5hp_state_t  nxt,
  output s5hp_pkg::s5hp_result_t res
);
  import s5hp_pkg::*;

  always_comb begin
    s5hp_state_t st;
    logic [7:0]  idx_inc;
    logic        complete;
    logic        av;
    logic [7:0]  aidx;
    logic [7:0]  abyte;

    st       = cur;
    complete = 1'b0;
    av       = 1'b0;
    aidx     = 8'd0;
    abyte    = 8'd0;

    if (first) begin
      st.error = ST_OK;
      st.index = 8'd0;
      if (op) begin
        st.phase   = PH_R_VER;
        st.command = 8'd0;
        st.atyp    = 8'd0;
        st.port    = 16'd0;
      end else begin
        st.phase   = PH_G_VER;
        st.methods = 3'd0;
      end
    end

    idx_inc = st.index + 8'd1;

    if (st.error == ST_OK) begin
      case (st.phase)
        PH_G_VER: begin
          if (data_byte != SOCKS_VERSION) st.error = ST_BAD_VER;
          else st.phase = PH_G_NMETH;
        end
        PH_G_NMETH: begin
          st.index = 8'd0;
          st.count = data_byte;
          if (data_byte == 8'd0) begin
            st.phase = PH_G_DONE;
            complete = 1'b1;
          end else begin
            st.phase = PH_G_METH;
          end
        end
        PH_G_METH: begin
          if (data_byte <= METHOD_MAX) begin
            st.methods = st.methods | (3'b001 << data_byte[1:0]);
          end
          st.index = idx_inc;
          if (idx_inc == st.count) begin
            st.phase = PH_G_DONE;
            complete = 1'b1;
          end
        end
        PH_G_DONE: st.error = ST_G_JUNK;
        PH_R_VER: begin
          if (data_byte != SOCKS_VERSION) st.error = ST_BAD_VER;
          else st.phase = PH_R_CMD;
        end
        PH_R_CMD: begin
          if (data_byte != CMD_CONNECT && data_byte != CMD_UDP_ASSOC) begin
            st.error = ST_BAD_CMD;
          end else begin
            st.command = data_byte;
            st.phase   = PH_R_RSV;
          end
        end
        PH_R_RSV: st.phase = PH_R_ATYP;
        PH_R_ATYP: begin
          st.atyp  = data_byte;
          st.index = 8'd0;
          if (data_byte == ATYP_IPV4) begin
            st.count = IPV4_LEN;
            st.phase = PH_R_ADDR;
          end else if (data_byte == ATYP_DOMAIN) begin
            st.phase = PH_R_ALEN;
          end else if (data_byte == ATYP_IPV6) begin
            st.count = IPV6_LEN;
            st.phase = PH_R_ADDR;
          end else begin
            st.error = ST_BAD_ATYP;
          end
        end
        PH_R_ALEN: begin
          st.index = 8'd0;
          st.count = data_byte;
          st.phase = (data_byte == 8'd0) ? PH_R_PORT : PH_R_ADDR;
        end
        PH_R_ADDR: begin
          av    = 1'b1;
          aidx  = st.index;
          abyte = data_byte;
          if (idx_inc == st.count) begin
            st.index = 8'd0;
            st.count = PORT_LEN;
            st.phase = PH_R_PORT;
          end else begin
            st.index = idx_inc;
          end
        end
        PH_R_PORT: begin
          if (st.index == 8'd0) begin
            st.port  = {data_byte, 8'd0};
            st.index = 8'd1;
          end else begin
            st.port  = {st.port[15:8], data_byte};
            st.phase = PH_R_DONE;
            complete = 1'b1;
          end
        end
        PH_R_DONE: st.error = ST_R_JUNK;
        default:   st.phase = PH_G_VER;
      endcase
    end

    nxt = st;
    res = '{
      status: st.error, complete: complete, method_mask: st.methods,
      command: st.command, address_type: st.atyp, port: st.port,
      addr_valid: av, addr_index: aidx, addr_byte: abyte
    };
  end

endmodule

FILE: design/socks5_handshake_parser_core.sv
// SOCKS5 greeting and request parser, one byte per beat. Each accepted beat
// gives exactly one result beat, and a new byte can be taken every cycle
// unless a held output stalls both stages. A byte passes an input register
// and is then parsed by the per-byte state update into the result register.
// Address bytes are passed through with their index instead of being stored,
// and an error stays reported until the next byte marked first.
`include "socks5_handshake_parser_core_defines.svh"

module socks5_handshake_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_complete,
  output logic [2:0]  out_method_mask,
  output logic [7:0]  out_command,
  output logic [7:0]  out_address_type,
  output logic [15:0] out_port,
  output logic        out_addr_valid,
  output logic [7:0]  out_addr_index,
  output logic [7:0]  out_addr_byte
);
  import s5hp_pkg::*;

  logic         s1_valid_r;
  logic         s1_op_r;
  logic [7:0]   s1_byte_r;
  logic         s1_first_r;
  logic         s2_valid_r;
  s5hp_result_t s2_res_r;
  s5hp_state_t  state_r;
  s5hp_state_t  state_nxt;
  s5hp_result_t res_nxt;
  logic         s2_load;
  logic         s1_load;
  logic         s1_move;

  s5hp_step u_step (
    .cur       (state_r),
    .op        (s1_op_r),
    .data_byte (s1_byte_r),
    .first     (s1_first_r),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  assign s2_load  = !s2_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && s2_load;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      state_r    <= STATE_RESET;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (s2_load) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s1_move) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_op_r    <= in_op;
      s1_byte_r  <= in_data_byte;
      s1_first_r <= in_first;
    end
    if (s1_move) begin
      s2_res_r <= res_nxt;
    end
  end

  assign out_valid        = s2_valid_r;
  assign out_status       = s2_res_r.status;
  assign out_complete     = s2_res_r.complete;
  assign out_method_mask  = s2_res_r.method_mask;
  assign out_command      = s2_res_r.command;
  assign out_address_type = s2_res_r.address_type;
  assign out_port         = s2_res_r.port;
  assign out_addr_valid   = s2_res_r.addr_valid;
  assign out_addr_index   = s2_res_r.addr_index;
  assign out_addr_byte    = s2_res_r.addr_byte;

  `S5HP_ASSERT_NOW(a_addr_not_complete, s2_valid_r && s2_res_r.addr_valid, !s2_res_r.complete, "address beat flagged complete")
  `S5HP_ASSERT_NOW(a_error_quiet, s2_valid_r && (s2_res_r.status != ST_OK), !s2_res_r.complete && !s2_res_r.addr_valid, "error beat carries complete or address")
  `S5HP_ASSERT_NEXT(a_state_holds, !s1_move, $stable(state_r), "parse state changed without a byte")
  `S5HP_ASSERT_NOW(a_full_stalls, s1_valid_r && s2_valid_r && out_stall, in_stall, "input taken while both stages are held")

endmodule
